// ----- src/lpd_pkg.sv -----
// lpd_pkg: shared constants, types and helper functions for the lidar packet decoder
// used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int SAMPLES_PER_PACKET = 16;
    localparam int PKT_LEN            = 12 + 3 * SAMPLES_PER_PACKET;
    localparam int HDR_LEN            = 4;
    localparam int OFS_SPEED          = 4;
    localparam int OFS_START          = 6;
    localparam int OFS_SAMPLES        = 8;
    localparam int OFS_END            = OFS_SAMPLES + 3 * SAMPLES_PER_PACKET;

    localparam int CNT_W   = $clog2(PKT_LEN + 1);
    localparam int IDX_W   = $clog2(SAMPLES_PER_PACKET);
    localparam int DIV_DEN = SAMPLES_PER_PACKET - 1;

    // reciprocal of the sample span, exact for every span below 360 degrees
    localparam int DIV_SHIFT = 20;
    localparam int DIV_MUL   = (2 ** DIV_SHIFT + DIV_DEN - 1) / DIV_DEN;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int ANG_W  = 9;
    localparam int DIST_W = 14;
    localparam int SPD_W  = 10;
    localparam int SIDX_W = 4;

    localparam int ANG_BIAS    = 40960;
    localparam int ANG_MIN_RAW = 40897;
    localparam int ANG_LIM_RAW = 64000;
    localparam int ANG_SHIFT   = 6;
    localparam int SPD_SHIFT   = 6;
    localparam int DEG_FULL    = 360;

    localparam logic [BYTE_W-1:0] HDR_0 = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_1 = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_2 = 8'h23;
    localparam logic [BYTE_W-1:0] HDR_3 = 8'h10;

    // byte position within a three-byte sample
    localparam logic [1:0] TRI_LO  = 2'd0;
    localparam logic [1:0] TRI_HI  = 2'd1;
    localparam logic [1:0] TRI_PAD = 2'd2;

    typedef struct packed {
        logic             store;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
        logic [1:0]       tpos;
        logic             chk;
        logic             div_step;
        logic             emit_rd;
        logic             emit_ld;
    } t_cmd;

    typedef struct packed {
        logic hdr_match;
        logic ang_ok;
        logic out_free;
    } t_stat;

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] k);
        logic [BYTE_W-1:0] b;
        unique case (k)
            2'd0:    b = HDR_0;
            2'd1:    b = HDR_1;
            2'd2:    b = HDR_2;
            default: b = HDR_3;
        endcase
        return b;
    endfunction

    function automatic logic ang_ok(input logic [WORD_W-1:0] raw);
        return (raw >= WORD_W'(ANG_MIN_RAW)) && (raw < WORD_W'(ANG_LIM_RAW));
    endfunction

    // truncation toward zero maps raw values just below the bias to zero
    function automatic logic [ANG_W-1:0] ang_deg(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] d;
        d = raw - WORD_W'(ANG_BIAS);
        if (raw >= WORD_W'(ANG_BIAS)) begin
            return ANG_W'(d >> ANG_SHIFT);
        end
        return '0;
    endfunction

endpackage

// ----- src/lpd_byte_if.sv -----
// lpd_byte_if: valid/ready channel carrying one received serial byte per beat
// depends on lpd_pkg
`timescale 1ns / 1ps

interface lpd_byte_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/lpd_res_if.sv -----
// lpd_res_if: valid/ready channel carrying one decoded sample per beat
// depends on lpd_pkg
`timescale 1ns / 1ps

interface lpd_res_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ANG_W-1:0]  angle_deg;
    logic [DIST_W-1:0] distance;
    logic [SPD_W-1:0]  speed_rpm;
    logic [SIDX_W-1:0] sample_index;
    logic              last;

    modport source (output valid, output angle_deg, output distance, output speed_rpm,
                    output sample_index, output last, input ready);
    modport sink   (input valid, input angle_deg, input distance, input speed_rpm,
                    input sample_index, input last, output ready);
endinterface

// ----- src/lidar_packet_decoder_core.sv -----
// lidar_packet_decoder_core: top level of the scanning rangefinder packet decoder
// depends on lpd_pkg, lpd_byte_if, lpd_res_if, lpd_ctrl and lpd_dp
//
// i_rx carries one received serial byte per beat. The block hunts for the header
// 55 AA 23 10, collects the rest of the packet and decodes it once the last byte
// is in. o_res carries one sample per beat: interpolated angle, 14-bit distance,
// speed/64, sample index and a last flag on the final sample of a packet.
// Bytes are taken at one per cycle while a packet is being collected.
// After the last byte: the angles are checked (a bad packet is dropped and the hunt
// resumes the next cycle), then the angle span is split over the samples by a
// reciprocal multiply, then each sample is read from the sample ram and loaded
// into the result register, with i_rx.ready low throughout.
// A stalled receiver holds the result register and the sequencer waits; i_rx
// is ready again as soon as the final sample is loaded, before it is taken.
// Synchronous active-low reset returns to the header hunt and empties the
// result register; the sample ram is not cleared.
`timescale 1ns / 1ps

module lidar_packet_decoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpd_byte_if.sink  i_rx,
    lpd_res_if.source o_res
);
    import lpd_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic w_rx_ready;

    lpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (w_rx_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_rx.ready = w_rx_ready;

    lpd_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_byte (i_rx.rx_byte),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_res     (o_res)
    );
endmodule

// ----- src/lpd_ram.sv -----
// lpd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/lpd_ctrl.sv -----
// lpd_ctrl: packet framing and sequencing state machine
// depends on lpd_pkg; drives the datapath through t_cmd and reads t_stat
`timescale 1ns / 1ps

module lpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  lpd_pkg::t_stat i_stat,
    output lpd_pkg::t_cmd  o_cmd
);
    import lpd_pkg::*;

    typedef enum logic [6:0] {
        S_HUNT    = 7'b0000001,
        S_HEADER  = 7'b0000010,
        S_PAYLOAD = 7'b0000100,
        S_CHECK   = 7'b0001000,
        S_DIV     = 7'b0010000,
        S_RD      = 7'b0100000,
        S_LD      = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_tri, n_tri;
    logic             w_acc;

    assign o_rx_ready = (r_state == S_HUNT) || (r_state == S_HEADER) ||
                        (r_state == S_PAYLOAD);
    assign w_acc      = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_idx          = r_idx;
        n_tri          = r_tri;
        o_cmd          = '0;
        o_cmd.cnt      = r_cnt;
        o_cmd.idx      = r_idx;
        o_cmd.tpos     = r_tri;
        unique case (r_state)
            S_HUNT: begin
                if (w_acc && i_stat.hdr_match) begin
                    n_cnt   = CNT_W'(1);
                    n_state = S_HEADER;
                end
            end
            S_HEADER: begin
                if (w_acc) begin
                    if (i_stat.hdr_match) begin
                        n_cnt = r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(HDR_LEN - 1)) begin
                            n_state = S_PAYLOAD;
                        end
                    end else begin
                        n_cnt   = '0;
                        n_state = S_HUNT;
                    end
                end
            end
            S_PAYLOAD: begin
                if (w_acc) begin
                    o_cmd.store = 1'b1;
                    n_cnt       = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(OFS_SAMPLES - 1)) begin
                        n_idx = '0;
                        n_tri = TRI_LO;
                    end else if (r_cnt >= CNT_W'(OFS_SAMPLES) && r_cnt < CNT_W'(OFS_END)) begin
                        if (r_tri == TRI_PAD) begin
                            n_tri = TRI_LO;
                            n_idx = r_idx + IDX_W'(1);
                        end else if (r_tri == TRI_LO) begin
                            n_tri = TRI_HI;
                        end else begin
                            n_tri = TRI_PAD;
                        end
                    end
                    if (r_cnt == CNT_W'(PKT_LEN - 1)) begin
                        n_cnt   = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_cnt     = '0;
                n_state   = i_stat.ang_ok ? S_DIV : S_HUNT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_idx          = '0;
                n_state        = S_RD;
            end
            S_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_LD;
            end
            S_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (r_idx == IDX_W'(SAMPLES_PER_PACKET - 1)) begin
                        n_state = S_HUNT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_tri   <= TRI_LO;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_tri   <= n_tri;
        end
    end
endmodule

// ----- src/lpd_dp.sv -----
// lpd_dp: field capture, sample store, angle checks, span divider and result register
// depends on lpd_pkg, lpd_ram and lpd_res_if
`timescale 1ns / 1ps

module lpd_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lpd_pkg::BYTE_W-1:0] i_rx_byte,
    input  lpd_pkg::t_cmd              i_cmd,
    output lpd_pkg::t_stat             o_stat,
    lpd_res_if.source                  o_res
);
    import lpd_pkg::*;

    logic [WORD_W-1:0] r_speed, r_start, r_end;
    logic [BYTE_W-1:0] r_lo;
    logic [ANG_W-1:0]  r_a0, r_dv, r_dq, r_qacc;
    logic [IDX_W-1:0]  r_rem, r_racc;
    logic              r_o_valid;
    logic [ANG_W-1:0]  r_o_ang;
    logic [DIST_W-1:0] r_o_dist;
    logic [SPD_W-1:0]  r_o_spd;
    logic [SIDX_W-1:0] r_o_sidx;
    logic              r_o_last;

    logic              w_in_samp, w_wr_en;
    logic [DIST_W-1:0] w_rd_dist;
    logic [ANG_W-1:0]  w_a0, w_a1, w_delta, w_qnext, w_ang;
    logic [ANG_W:0]    w_dwrap, w_qsum, w_asum;
    logic [ANG_W+DIV_SHIFT:0] w_prod;
    logic [ANG_W-1:0]  w_dq;
    logic [IDX_W-1:0]  w_drem;
    logic [IDX_W:0]    w_rsum;
    logic              w_rcarry;
    logic [IDX_W-1:0]  w_rnext;

    assign w_in_samp = (i_cmd.cnt >= CNT_W'(OFS_SAMPLES)) && (i_cmd.cnt < CNT_W'(OFS_END));
    assign w_wr_en   = i_cmd.store && w_in_samp && (i_cmd.tpos == TRI_HI);

    lpd_ram #(
        .WIDTH (DIST_W),
        .DEPTH (SAMPLES_PER_PACKET)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_cmd.idx),
        .i_wr_data ({i_rx_byte[DIST_W-BYTE_W-1:0], r_lo}),
        .i_rd_en   (i_cmd.emit_rd),
        .i_rd_addr (i_cmd.idx),
        .o_rd_data (w_rd_dist)
    );

    // angle conversion and wrap distance between start and end
    always_comb begin
        w_a0    = ang_deg(r_start);
        w_a1    = ang_deg(r_end);
        w_dwrap = {1'b0, w_a1} + (ANG_W + 1)'(DEG_FULL) - {1'b0, w_a0};
        w_delta = (w_a1 >= w_a0) ? (w_a1 - w_a0) : w_dwrap[ANG_W-1:0];
    end

    // delta split by the sample span through a reciprocal multiply
    always_comb begin
        w_prod = (ANG_W + DIV_SHIFT + 1)'(r_dv) * (ANG_W + DIV_SHIFT + 1)'(DIV_MUL);
        w_dq   = ANG_W'(w_prod >> DIV_SHIFT);
        w_drem = IDX_W'(r_dv - ANG_W'(w_dq * ANG_W'(DIV_DEN)));
    end

    // quotient/remainder accumulation of delta*i/span
    always_comb begin
        w_rsum   = {1'b0, r_racc} + {1'b0, r_rem};
        w_rcarry = w_rsum >= (IDX_W + 1)'(DIV_DEN);
        w_rnext  = w_rcarry ? IDX_W'(w_rsum - (IDX_W + 1)'(DIV_DEN)) : w_rsum[IDX_W-1:0];
        w_qsum   = {1'b0, r_qacc} + {1'b0, r_dq} + (ANG_W + 1)'(w_rcarry);
        w_qnext  = w_qsum[ANG_W-1:0];
        w_asum   = {1'b0, r_a0} + {1'b0, r_qacc};
        w_ang    = (w_asum >= (ANG_W + 1)'(DEG_FULL)) ?
                   ANG_W'(w_asum - (ANG_W + 1)'(DEG_FULL)) : w_asum[ANG_W-1:0];
    end

    assign o_stat.hdr_match = (i_rx_byte == hdr_byte(i_cmd.cnt[1:0]));
    assign o_stat.ang_ok    = ang_ok(r_start) && ang_ok(r_end);
    assign o_stat.out_free  = !r_o_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (i_cmd.cnt == CNT_W'(OFS_SPEED))     r_speed[7:0]  <= i_rx_byte;
            if (i_cmd.cnt == CNT_W'(OFS_SPEED + 1)) r_speed[15:8] <= i_rx_byte;
            if (i_cmd.cnt == CNT_W'(OFS_START))     r_start[7:0]  <= i_rx_byte;
            if (i_cmd.cnt == CNT_W'(OFS_START + 1)) r_start[15:8] <= i_rx_byte;
            if (i_cmd.cnt == CNT_W'(OFS_END))       r_end[7:0]    <= i_rx_byte;
            if (i_cmd.cnt == CNT_W'(OFS_END + 1))   r_end[15:8]   <= i_rx_byte;
            if (w_in_samp && i_cmd.tpos == TRI_LO)  r_lo          <= i_rx_byte;
        end
        if (i_cmd.chk) begin
            r_a0   <= w_a0;
            r_dv   <= w_delta;
            r_qacc <= '0;
            r_racc <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq  <= w_dq;
            r_rem <= w_drem;
        end
        if (i_cmd.emit_ld) begin
            r_o_ang  <= w_ang;
            r_o_dist <= w_rd_dist;
            r_o_spd  <= SPD_W'(r_speed >> SPD_SHIFT);
            r_o_sidx <= SIDX_W'(i_cmd.idx);
            r_o_last <= (i_cmd.idx == IDX_W'(SAMPLES_PER_PACKET - 1));
            r_qacc   <= w_qnext;
            r_racc   <= w_rnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.angle_deg    = r_o_ang;
    assign o_res.distance     = r_o_dist;
    assign o_res.speed_rpm    = r_o_spd;
    assign o_res.sample_index = r_o_sidx;
    assign o_res.last         = r_o_last;
endmodule

// ----- tb/sv/lidar_packet_decoder_core_test.sv -----
// lidar_packet_decoder_core_test: self-checking bench for the rangefinder packet decoder
// depends on lpd_pkg, lpd_byte_if, lpd_res_if and lidar_packet_decoder_core
// directed packet table first, then random packets, broken headers and noise
`timescale 1ns / 1ps

module lidar_packet_decoder_core_test;
    import lpd_pkg::*;

    localparam int LIMIT      = 300000;
    localparam int RAND_BYTES = 40;
    localparam int DRAIN      = 80;
    localparam int N_ROWS     = 11;

    localparam logic [BYTE_W-1:0] SYNC [HDR_LEN] = '{HDR_0, HDR_1, HDR_2, HDR_3};

    typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD} parse_phase_e;
    typedef enum logic {ROW_BYTES, ROW_PKT} row_kind_e;

    typedef struct packed {
        logic [ANG_W-1:0]  angle;
        logic [DIST_W-1:0] distance;
        logic [SPD_W-1:0]  speed;
        logic [SIDX_W-1:0] index;
        logic              last;
    } sample_t;

    typedef struct {
        row_kind_e   kind;
        logic [47:0] seq;
        int          seq_n;
        logic [15:0] spd;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [15:0] dist_base;
        logic [15:0] dist_inc;
        bit          typed;
        int          typ_n;
        int          typ_ang;
        int          typ_dist;
        int          typ_spd;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    lpd_byte_if rx_ch ();
    lpd_res_if  res_ch ();

    lidar_packet_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // decoder shadow state
    parse_phase_e      phase;
    int                byte_cnt;
    logic [BYTE_W-1:0] pkt_mem [PKT_LEN];
    sample_t           decoded [SAMPLES_PER_PACKET];

    sample_t exp_samples [$];
    int      fail_cnt = 0;
    int      taken_cnt;
    int      cycle_cnt = 0;
    bit      use_typed;
    logic    quiet_win;

    stim_row_t dir_rows [N_ROWS];

    assign quiet_win = (cycle_cnt >= 200) && (cycle_cnt < 600);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int le_word(input int ofs);
        return int'({pkt_mem[ofs + 1], pkt_mem[ofs]});
    endfunction

    function automatic int deg_of(input int raw);
        int q;
        q = (raw - ANG_BIAS) / 64;
        if (q < 0 || q >= DEG_FULL) begin
            return -1;
        end
        return q;
    endfunction

    function automatic int step_decoder(input logic [BYTE_W-1:0] b);
        int n;
        int a0;
        int a1;
        int delta;
        int ang;
        int spd;
        n = 0;
        case (phase)
            PH_HUNT: begin
                if (b == SYNC[0]) begin
                    pkt_mem[0] = b;
                    byte_cnt   = 1;
                    phase      = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (byte_cnt < HDR_LEN && b == SYNC[byte_cnt]) begin
                    pkt_mem[byte_cnt] = b;
                    byte_cnt++;
                    if (byte_cnt == HDR_LEN) begin
                        phase = PH_PAYLOAD;
                    end
                end else begin
                    byte_cnt = 0;
                    phase    = PH_HUNT;
                end
            end
            default: begin
                if (byte_cnt < PKT_LEN) begin
                    pkt_mem[byte_cnt] = b;
                    byte_cnt++;
                end
                if (byte_cnt >= PKT_LEN) begin
                    a0 = deg_of(le_word(OFS_START));
                    a1 = deg_of(le_word(OFS_END));
                    if (a0 >= 0 && a1 >= 0) begin
                        spd   = le_word(OFS_SPEED) / 64;
                        delta = (a1 < a0) ? a1 - a0 + DEG_FULL : a1 - a0;
                        for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
                            ang = a0 + delta * i / (SAMPLES_PER_PACKET - 1);
                            if (ang >= DEG_FULL) begin
                                ang -= DEG_FULL;
                            end
                            decoded[i].angle    = ANG_W'(ang);
                            decoded[i].distance = DIST_W'(le_word(OFS_SAMPLES + 3 * i));
                            decoded[i].speed    = SPD_W'(spd);
                            decoded[i].index    = SIDX_W'(i);
                            decoded[i].last     = (i == SAMPLES_PER_PACKET - 1);
                        end
                        n = SAMPLES_PER_PACKET;
                    end
                    byte_cnt = 0;
                    phase    = PH_HUNT;
                end
            end
        endcase
        return n;
    endfunction

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        int  n;
        bit  ignored;
        while (!quiet_win && $urandom_range(99) < 14) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        ignored = (phase == PH_HUNT) && (b != SYNC[0]);
        n = step_decoder(b);
        if (!ignored) begin
            taken_cnt++;
        end
        if (!use_typed) begin
            for (int k = 0; k < n; k++) begin
                exp_samples.push_back(decoded[k]);
            end
        end
    endtask

    task automatic send_packet(input logic [15:0] spd_w, input logic [15:0] a0_w,
                               input logic [15:0] a1_w, input logic [15:0] dist_w,
                               input logic [15:0] dist_inc, input bit dist_rnd);
        logic [BYTE_W-1:0] pkt [PKT_LEN];
        logic [15:0]       d;
        for (int i = 0; i < HDR_LEN; i++) begin
            pkt[i] = SYNC[i];
        end
        {pkt[OFS_SPEED + 1], pkt[OFS_SPEED]} = spd_w;
        {pkt[OFS_START + 1], pkt[OFS_START]} = a0_w;
        for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
            d = dist_rnd ? 16'($urandom) : 16'(dist_w + i * dist_inc);
            {pkt[OFS_SAMPLES + 3 * i + 1], pkt[OFS_SAMPLES + 3 * i]} = d;
            pkt[OFS_SAMPLES + 3 * i + 2] = 8'($urandom);
        end
        {pkt[OFS_END + 1], pkt[OFS_END]} = a1_w;
        pkt[PKT_LEN - 2] = 8'($urandom);
        pkt[PKT_LEN - 1] = 8'($urandom);
        for (int i = 0; i < PKT_LEN; i++) begin
            put_byte(pkt[i]);
        end
    endtask

    // mostly legal angles, some just under the bias, some anything
    function automatic logic [15:0] rnd_angle();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'(ANG_MIN_RAW + $urandom_range(62));
            default: return 16'(ANG_BIAS + $urandom_range(359) * 64 + $urandom_range(63));
        endcase
    endfunction

    function automatic void cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        res_ch.ready <= quiet_win || ($urandom_range(99) >= 14);
    end

    always @(posedge i_clk) begin
        sample_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (exp_samples.size() == 0) begin
                $display("%0t: unexpected sample, actual angle %0d distance %0d index %0d",
                         $time, res_ch.angle_deg, res_ch.distance, res_ch.sample_index);
                fail_cnt++;
            end else begin
                want = exp_samples.pop_front();
                cmp_field("angle_deg", want.angle, res_ch.angle_deg);
                cmp_field("distance", want.distance, res_ch.distance);
                cmp_field("speed_rpm", want.speed, res_ch.speed_rpm);
                cmp_field("sample_index", want.index, res_ch.sample_index);
                cmp_field("last", want.last, res_ch.last);
            end
        end
        if (cycle_cnt >= LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding", $time, exp_samples.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        stim_row_t         r;
        sample_t           s;
        int                pick;
        int                k;
        int                rand_base;
        logic [BYTE_W-1:0] bad;

        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        taken_cnt     = 0;
        use_typed     = 1'b0;
        phase         = PH_HUNT;
        byte_cnt      = 0;

        // kind, bytes, count, speed, start, end, dist, dist step, typed, n, angle, dist, speed
        dir_rows = '{
            '{ROW_BYTES, 48'h00FFAA231000, 5, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
            '{ROW_PKT, 0, 0, 16'h0000, 16'd40960, 16'd40960, 16'h0000, 0, 1, 16, 0, 0, 0},
            '{ROW_PKT, 0, 0, 16'hFFFF, 16'd63999, 16'd63999, 16'hFFFF, 0, 1, 16, 359, 16383,
              1023},
            '{ROW_PKT, 0, 0, 16'h0040, 16'd40897, 16'd40897, 16'hC001, 0, 1, 16, 0, 1, 1},
            '{ROW_PKT, 0, 0, 16'h1234, 16'd40896, 16'd40960, 16'h0100, 0, 1, 0, 0, 0, 0},
            '{ROW_PKT, 0, 0, 16'h1234, 16'd40960, 16'd64000, 16'h0100, 0, 1, 0, 0, 0, 0},
            '{ROW_BYTES, 48'h55AA23110000, 4, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
            '{ROW_BYTES, 48'h5555AA231000, 5, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
            '{ROW_BYTES, 48'h55AA55000000, 3, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
            '{ROW_PKT, 0, 0, 16'h4B00, 16'd63360, 16'd41600, 16'h1234, 16'h0457, 0, 0, 0, 0, 0},
            '{ROW_PKT, 0, 0, 16'h003F, 16'd41024, 16'd40960, 16'hBFFF, 16'h1001, 0, 0, 0, 0, 0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < N_ROWS; row++) begin
            r = dir_rows[row];
            use_typed = r.typed;
            if (r.kind == ROW_BYTES) begin
                for (int j = 0; j < r.seq_n; j++) begin
                    put_byte(r.seq[47 - 8 * j -: 8]);
                end
            end else begin
                send_packet(r.spd, r.a0, r.a1, r.dist_base, r.dist_inc, 1'b0);
            end
            if (r.typed) begin
                for (int j = 0; j < r.typ_n; j++) begin
                    s.angle    = ANG_W'(r.typ_ang);
                    s.distance = DIST_W'(r.typ_dist);
                    s.speed    = SPD_W'(r.typ_spd);
                    s.index    = SIDX_W'(j);
                    s.last     = (j == SAMPLES_PER_PACKET - 1);
                    exp_samples.push_back(s);
                end
            end
        end
        use_typed = 1'b0;

        rand_base = taken_cnt;
        while (taken_cnt - rand_base < RAND_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_packet(16'($urandom), rnd_angle(), rnd_angle(), '0, '0, 1'b1);
            end else if (pick < 88) begin
                // partial header then a wrong byte
                k = $urandom_range(1, HDR_LEN - 1);
                for (int j = 0; j < k; j++) begin
                    put_byte(SYNC[j]);
                end
                do bad = 8'($urandom); while (bad == SYNC[k]);
                put_byte(bad);
            end else begin
                k = $urandom_range(1, 6);
                for (int j = 0; j < k; j++) begin
                    put_byte(8'($urandom));
                end
            end
        end

        rx_ch.valid <= 1'b0;
        while (exp_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- lidar_packet_decoder_core.f -----
src/lpd_pkg.sv
src/lpd_byte_if.sv
src/lpd_res_if.sv
src/lpd_ram.sv
src/lpd_ctrl.sv
src/lpd_dp.sv
src/lidar_packet_decoder_core.sv
tb/sv/lidar_packet_decoder_core_test.sv
